// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the string to int64 parser.
// No dependencies; the macros expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/s2i_pkg.sv =====
// Package of the string to int64 parser: types, constants and the byte classifier.
// Used by every module of the block; has no dependencies.
`timescale 1ns / 1ps

package s2i_pkg;

    localparam int unsigned MAX_OFFSET = 4095;
    localparam int unsigned CNT_W = 12;
    localparam logic [CNT_W-1:0] OFFSET_LIMIT =
        (MAX_OFFSET < 4095) ? CNT_W'(MAX_OFFSET) : CNT_W'(4095);

    localparam int unsigned RADIX_W = 6;
    localparam int unsigned DIG_W = 6;
    localparam logic [DIG_W-1:0] DIG_NONE = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
    localparam logic [RADIX_W-1:0] RADIX_ONE = 6'd1;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

    localparam logic [63:0] INT64_MIN_MAG = 64'h8000_0000_0000_0000;
    localparam logic [63:0] INT64_MAX_VAL = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam int unsigned CFG_AW = 1;
    localparam logic [CFG_AW-1:0] CFG_RADIX = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_UNSIGNED = 1'b1;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW = 1;
    localparam int unsigned QUEUE_CW = 2;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_START,
        PH_ZERO,
        PH_DIGITS
    } t_phase;

    typedef struct packed {
        logic             blank;
        logic             sign;
        logic             minus;
        logic             zero;
        logic             xch;
        logic [DIG_W-1:0] dig;
    } t_tok;

    typedef struct packed {
        logic [63:0]      value;
        logic [CNT_W-1:0] end_offset;
    } t_res;

    function automatic t_tok f_classify(input logic [7:0] c);
        t_tok t;
        t.blank = ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
        t.sign  = (c == 8'h2B) || (c == 8'h2D);
        t.minus = (c == 8'h2D);
        t.zero  = (c == 8'h30);
        t.xch   = (c == 8'h78) || (c == 8'h58);
        if ((c >= 8'h30) && (c <= 8'h39)) begin
            t.dig = DIG_W'(c - 8'h30);
        end else if ((c >= 8'h61) && (c <= 8'h7A)) begin
            t.dig = DIG_W'(c - 8'h61 + 8'd10);
        end else if ((c >= 8'h41) && (c <= 8'h5A)) begin
            t.dig = DIG_W'(c - 8'h41 + 8'd10);
        end else begin
            t.dig = DIG_NONE;
        end
        return t;
    endfunction

endpackage

// ===== rtl/string_to_int64_parser.sv =====
// Top level of the streaming strtoll / strtoull parser with its configuration registers.
// Depends on s2i_pkg, s2i_front, s2i_back, s2i_resq and assert_macros.svh.
//
//   Channel   Handshake           Payload
//   input     push / full         i_char_in (one byte per transfer)
//   result    empty / pop         o_value, o_end_offset
//   config    i_cfg_we            i_cfg_addr (0 radix, 1 unsigned_mode), i_cfg_data
//
// One byte is taken every cycle while full is low; the limit is the 64 by 6 bit multiply-add in the back end.
// A result passes the byte queue and the result queue registers before it reaches the result ports.
// Synchronous reset clears the registers and empties both queues; no clearing pass is needed.
// A full result queue stalls the back end, which in turn fills the two-entry byte queue.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module string_to_int64_parser (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  logic [7:0]                           i_char_in,
    output logic                                 empty,
    input  logic                                 pop,
    output logic [63:0]                          o_value,
    output logic [s2i_pkg::CNT_W-1:0]            o_end_offset,
    input  logic                                 i_cfg_we,
    input  logic [s2i_pkg::CFG_AW-1:0]           i_cfg_addr,
    input  logic [s2i_pkg::RADIX_W-1:0]          i_cfg_data
);

    logic [s2i_pkg::RADIX_W-1:0] r_radix;
    logic                        r_unsigned_mode;

    logic          w_tok_valid, w_tok_pop, w_res_ready, w_res_push;
    s2i_pkg::t_tok w_tok;
    s2i_pkg::t_res w_res, w_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix         <= s2i_pkg::RADIX_DEC;
            r_unsigned_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                s2i_pkg::CFG_RADIX:    r_radix <= i_cfg_data;
                s2i_pkg::CFG_UNSIGNED: r_unsigned_mode <= i_cfg_data[0];
                default:               r_radix <= r_radix;
            endcase
        end
    end

    s2i_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_char_in   (i_char_in),
        .o_full      (full),
        .o_tok_valid (w_tok_valid),
        .o_tok       (w_tok),
        .i_tok_pop   (w_tok_pop)
    );

    s2i_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tok_valid     (w_tok_valid),
        .i_tok           (w_tok),
        .o_tok_pop       (w_tok_pop),
        .i_res_ready     (w_res_ready),
        .o_res_push      (w_res_push),
        .o_res           (w_res),
        .i_radix         (r_radix),
        .i_unsigned_mode (r_unsigned_mode)
    );

    s2i_resq u_resq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_push  (w_res_push),
        .i_res       (w_res),
        .o_res_ready (w_res_ready),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_res       (w_out)
    );

    assign o_value      = w_out.value;
    assign o_end_offset = w_out.end_offset;

    `ASSERT_IMPLIES(a_res_push_has_room, i_clk, i_rst_n, w_res_push, w_res_ready)
    `ASSERT_NEXT(a_byte_reaches_queue, i_clk, i_rst_n, push && !full, w_tok_valid)
    `ASSERT_NEXT(a_result_reaches_port, i_clk, i_rst_n, w_res_push, !empty)

endmodule

// ===== rtl/s2i_front.sv =====
// Front end of the parser: classifies each byte and holds the classes in a short queue.
// Depends on s2i_pkg.
`timescale 1ns / 1ps

module s2i_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [7:0]    i_char_in,
    output logic          o_full,
    output logic          o_tok_valid,
    output s2i_pkg::t_tok o_tok,
    input  logic          i_tok_pop
);

    s2i_pkg::t_tok r_mem [s2i_pkg::QUEUE_DEPTH];
    logic [s2i_pkg::QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [s2i_pkg::QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [s2i_pkg::QUEUE_CW-1:0] r_count, n_count;
    logic w_wr, w_rd;

    assign o_full      = (r_count == s2i_pkg::QUEUE_CW'(s2i_pkg::QUEUE_DEPTH));
    assign o_tok_valid = (r_count != '0);
    assign o_tok       = r_mem[r_rd_ptr];
    assign w_wr        = i_push && !o_full;
    assign w_rd        = i_tok_pop && o_tok_valid;

    always_comb begin
        n_wr_ptr = w_wr ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_rd ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + s2i_pkg::QUEUE_CW'(w_wr) - s2i_pkg::QUEUE_CW'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= s2i_pkg::f_classify(i_char_in);
        end
    end

endmodule

// ===== rtl/s2i_back.sv =====
// Back end of the parser: phase machine, 64-bit multiply-add accumulator and result forming.
// Depends on s2i_pkg.
`timescale 1ns / 1ps

module s2i_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_tok_valid,
    input  s2i_pkg::t_tok                  i_tok,
    output logic                           o_tok_pop,
    input  logic                           i_res_ready,
    output logic                           o_res_push,
    output s2i_pkg::t_res                  o_res,
    input  logic [s2i_pkg::RADIX_W-1:0]    i_radix,
    input  logic                           i_unsigned_mode
);

    s2i_pkg::t_phase r_phase, n_phase;
    logic [63:0]                  r_acc;
    logic                         r_neg;
    logic [s2i_pkg::RADIX_W-1:0]  r_base;
    logic [s2i_pkg::CNT_W-1:0]    r_cnt;
    logic [s2i_pkg::CNT_W-1:0]    r_off;

    logic w_fire, w_go_start, w_ill, w_pfx, w_start_zero, w_zero_x;
    logic w_go_digit, w_finish, w_accum, w_mark, w_ovf;
    logic [s2i_pkg::RADIX_W-1:0] w_eff_base;
    logic [s2i_pkg::CNT_W-1:0]   w_cnt_next;
    logic [69:0]                 w_prod;
    logic [63:0]                 w_value;

    assign w_fire    = i_tok_valid && i_res_ready;
    assign o_tok_pop = w_fire;

    // Decode of one byte against the current phase.
    always_comb begin
        w_ill = (i_radix == s2i_pkg::RADIX_ONE) || (i_radix > s2i_pkg::RADIX_MAX);
        w_pfx = ((i_radix == s2i_pkg::RADIX_AUTO) || (i_radix == s2i_pkg::RADIX_HEX))
                && i_tok.zero;
        w_go_start = ((r_phase == s2i_pkg::PH_LEAD) && !i_tok.blank && !i_tok.sign)
                     || (r_phase == s2i_pkg::PH_START);
        w_start_zero = w_go_start && !w_ill && w_pfx;
        w_zero_x = (r_phase == s2i_pkg::PH_ZERO) && i_tok.xch;
        w_go_digit = (w_go_start && !w_ill && !w_pfx)
                     || ((r_phase == s2i_pkg::PH_ZERO) && !i_tok.xch)
                     || (r_phase == s2i_pkg::PH_DIGITS);
        if (w_go_start) begin
            w_eff_base = (i_radix == s2i_pkg::RADIX_AUTO) ? s2i_pkg::RADIX_DEC : i_radix;
        end else begin
            w_eff_base = r_base;
        end
        w_finish = (w_go_start && w_ill) || (w_go_digit && (i_tok.dig >= w_eff_base));
        w_accum  = w_go_digit && !w_finish;
        w_mark   = w_start_zero || w_accum;
        w_cnt_next = (r_cnt == s2i_pkg::OFFSET_LIMIT) ? r_cnt : r_cnt + 1'b1;
        w_prod = 70'(r_acc) * 70'(w_eff_base) + 70'(i_tok.dig);
        w_ovf  = (w_prod[69:64] != '0);
    end

    always_comb begin
        n_phase = r_phase;
        if (w_fire) begin
            if (w_finish) begin
                n_phase = s2i_pkg::PH_LEAD;
            end else begin
                unique case (r_phase)
                    s2i_pkg::PH_LEAD: begin
                        if (i_tok.blank) begin
                            n_phase = s2i_pkg::PH_LEAD;
                        end else if (i_tok.sign) begin
                            n_phase = s2i_pkg::PH_START;
                        end else if (w_start_zero) begin
                            n_phase = s2i_pkg::PH_ZERO;
                        end else begin
                            n_phase = s2i_pkg::PH_DIGITS;
                        end
                    end
                    s2i_pkg::PH_START: begin
                        n_phase = w_start_zero ? s2i_pkg::PH_ZERO : s2i_pkg::PH_DIGITS;
                    end
                    s2i_pkg::PH_ZERO:   n_phase = s2i_pkg::PH_DIGITS;
                    s2i_pkg::PH_DIGITS: n_phase = s2i_pkg::PH_DIGITS;
                    default:            n_phase = s2i_pkg::PH_LEAD;
                endcase
            end
        end
    end

    // Result forming: sign handling and clamping to the int64 limits in signed mode.
    always_comb begin
        if (r_neg) begin
            if (!i_unsigned_mode && (r_acc > s2i_pkg::INT64_MIN_MAG)) begin
                w_value = s2i_pkg::INT64_MIN_MAG;
            end else begin
                w_value = 64'd0 - r_acc;
            end
        end else begin
            if (!i_unsigned_mode && r_acc[63]) begin
                w_value = s2i_pkg::INT64_MAX_VAL;
            end else begin
                w_value = r_acc;
            end
        end
        o_res_push       = w_fire && w_finish;
        o_res.value      = w_value;
        o_res.end_offset = r_off;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= s2i_pkg::PH_LEAD;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_base  <= '0;
            r_cnt   <= '0;
            r_off   <= '0;
        end else begin
            r_phase <= n_phase;
            if (w_fire) begin
                if (w_finish) begin
                    r_acc  <= '0;
                    r_neg  <= 1'b0;
                    r_base <= '0;
                    r_cnt  <= '0;
                    r_off  <= '0;
                end else begin
                    r_cnt <= w_cnt_next;
                    if (w_mark) begin
                        r_off <= w_cnt_next;
                    end
                    if ((r_phase == s2i_pkg::PH_LEAD) && !i_tok.blank && i_tok.sign) begin
                        r_neg <= i_tok.minus;
                    end
                    if (w_start_zero) begin
                        r_base <= (i_radix == s2i_pkg::RADIX_AUTO) ? s2i_pkg::RADIX_OCT
                                                                   : s2i_pkg::RADIX_HEX;
                    end else if (w_zero_x) begin
                        r_base <= s2i_pkg::RADIX_HEX;
                    end else if (w_go_start) begin
                        r_base <= w_eff_base;
                    end
                    if (w_accum) begin
                        if (w_ovf) begin
                            r_acc <= '1;
                            if (i_unsigned_mode) begin
                                r_neg <= 1'b0;
                            end
                        end else begin
                            r_acc <= w_prod[63:0];
                        end
                    end
                end
            end
        end
    end

endmodule

// ===== rtl/s2i_resq.sv =====
// Result queue of the parser: holds finished results until the consumer takes them.
// Depends on s2i_pkg.
`timescale 1ns / 1ps

module s2i_resq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_res_push,
    input  s2i_pkg::t_res i_res,
    output logic          o_res_ready,
    output logic          o_empty,
    input  logic          i_pop,
    output s2i_pkg::t_res o_res
);

    s2i_pkg::t_res r_mem [s2i_pkg::QUEUE_DEPTH];
    logic [s2i_pkg::QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [s2i_pkg::QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [s2i_pkg::QUEUE_CW-1:0] r_count, n_count;
    logic w_wr, w_rd;

    assign o_res_ready = (r_count != s2i_pkg::QUEUE_CW'(s2i_pkg::QUEUE_DEPTH));
    assign o_empty     = (r_count == '0);
    assign o_res       = r_mem[r_rd_ptr];
    assign w_wr        = i_res_push && o_res_ready;
    assign w_rd        = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = w_wr ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_rd ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count + s2i_pkg::QUEUE_CW'(w_wr) - s2i_pkg::QUEUE_CW'(w_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_res;
        end
    end

endmodule
